>>> rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the scheduler RTL. Every check is
// clocked on a rising edge and is switched off while reset is asserted.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> rtl/core/rrts_pkg.sv
// ============================================================================
// Round robin task scheduler package
// Types, codes and constants shared by the scheduler modules.
// ============================================================================
`default_nettype none

package rrts_pkg;

    localparam int TASK_ID_W = 6;
    localparam int SLICE_W   = 8;

    // Operation codes carried by a request transaction.
    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_BLOCK   = 3'd1,
        OP_UNBLOCK = 3'd2,
        OP_YIELD   = 3'd3,
        OP_PREEMPT = 3'd4,
        OP_EXIT    = 3'd5
    } t_op;

    // Per-task run states.
    typedef enum logic [2:0] {
        TS_RUNNING = 3'd0,
        TS_READY   = 3'd1,
        TS_BLOCKED = 3'd2,
        TS_WAITING = 3'd3,
        TS_HANGING = 3'd4,
        TS_DIED    = 3'd5
    } t_task_state;

    // Status codes returned with each result.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL     = 2'd1;
    localparam logic [1:0] STATUS_NO_RUNNABLE = 2'd2;

    // Largest legal block kind (hanging).
    localparam logic [1:0] BLOCK_KIND_MAX = 2'd2;

    // Slice values loaded by reset into task 0 and task 1.
    localparam logic [SLICE_W-1:0] TASK0_SLICE = 8'd31;
    localparam logic [SLICE_W-1:0] TASK1_SLICE = 8'd10;

    typedef struct packed {
        logic [2:0]           operation;
        logic [TASK_ID_W-1:0] task_id;
        logic [SLICE_W-1:0]   priority_req;
        logic [1:0]           block_kind;
        logic                 need_schedule;
    } t_sched_req;

    typedef struct packed {
        logic [TASK_ID_W-1:0] running_task;
        logic                 switched;
        logic [SLICE_W-1:0]   slice_ticks;
        logic [1:0]           status_code;
    } t_sched_rsp;

    // Non-link part of one task table entry.
    typedef struct packed {
        t_task_state        state;
        logic [SLICE_W-1:0] prio;
        logic [SLICE_W-1:0] ticks;
        logic               in_queue;
    } t_task_info;

    localparam int TASK_INFO_W = $bits(t_task_info);

    // Sequencer states of the scheduler core.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OP_RD,
        S_OP_WR,
        S_SCH_RD,
        S_SCH_WR,
        S_IDL_CHK,
        S_IDL_RD,
        S_IDL_WR,
        S_POP_RD,
        S_POP_WR,
        S_FIX_RD,
        S_FIX_WR,
        S_OUT_RD,
        S_OUT
    } t_fsm;

    function automatic logic is_sleeping(input t_task_state s);
        return (s == TS_BLOCKED) || (s == TS_WAITING) || (s == TS_HANGING);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rrts_ram.sv
// ============================================================================
// Generic simple dual port RAM
// One write port and one read port with a registered read data output.
// ============================================================================
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/round_robin_task_scheduler_unit.sv
// ============================================================================
// Round robin task scheduler
// Keeps per-task state, slice and ready queue links in one task table RAM and
// runs one scheduling operation per request transaction.
// ============================================================================
//
// Channel      Direction  Handshake                     Payload
// request      in         start high while busy low     i_req (t_sched_req)
// result       out        o_rsp_valid, one cycle        o_rsp (t_sched_rsp)
// idle config  in         i_cfg_we                      i_idle_task
//
// Each entry that an operation updates is read and then written on the single
// task table RAM, so the time from acceptance to the result strobe depends on
// how many entries the operation touches. After reset the block sweeps every
// task table entry with busy high; idle task writes are taken during that
// sweep as at any other time. The result is driven for exactly one cycle and
// cannot be stalled; the next request can be accepted in the cycle the result
// is shown.
//
`default_nettype none

`include "assert_macros.svh"

module round_robin_task_scheduler_unit import rrts_pkg::*; #(
    parameter int NUM_TASKS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_sched_req           i_req,
    output logic                      o_rsp_valid,
    output t_sched_rsp                o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [TASK_ID_W-1:0] i_idle_task
);

    // Task index width, queue count width and RAM word layout:
    // {task info, next link, prev link}.
    localparam int TW   = $clog2(NUM_TASKS);
    localparam int CNTW = $clog2(NUM_TASKS + 1);
    localparam int WW   = TASK_INFO_W + 2 * TW;

    // Sequencer and transaction registers.
    t_fsm            r_state, n_state;
    t_fsm            r_ret, n_ret;
    t_sched_req      r_req, n_req;
    logic [TW-1:0]   r_tgt, n_tgt;
    logic            r_sw, n_sw;
    logic [1:0]      r_status, n_status;

    // Ready queue bookkeeping and the currently running task.
    logic [TW-1:0]   r_cur, n_cur;
    logic [TW-1:0]   r_head, n_head;
    logic [TW-1:0]   r_tail, n_tail;
    logic [CNTW-1:0] r_count, n_count;
    logic [TASK_ID_W-1:0] r_idle;

    // Pending link updates on neighbor entries. Slot 0 is drained first.
    logic [1:0]      r_fix_v, n_fix_v;
    logic [TW-1:0]   r_fix_a [2];
    logic [TW-1:0]   n_fix_a [2];
    logic [1:0]      r_fix_nx, n_fix_nx;
    logic [TW-1:0]   r_fix_d [2];
    logic [TW-1:0]   n_fix_d [2];
    logic            fix_sel;

    // Reset sweep index.
    logic [TW-1:0]   r_clr, n_clr;

    // Result register.
    t_sched_rsp      r_rsp, n_rsp;
    logic            r_rsp_valid, n_rsp_valid;

    // Task table port signals.
    logic            ram_we;
    logic [TW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic            ram_re;
    logic [TW-1:0]   ram_raddr;
    logic [WW-1:0]   ram_rdata;

    t_task_info      rd_info;
    logic [TW-1:0]   rd_next;
    logic [TW-1:0]   rd_prev;
    t_task_info      w_info;
    logic [TW-1:0]   w_next;
    logic [TW-1:0]   w_prev;

    logic            tid_in_range;
    logic            idle_in_range;

    rrts_ram #(
        .WIDTH (WW),
        .DEPTH (NUM_TASKS)
    ) u_task_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_info = t_task_info'(ram_rdata[WW-1 -: TASK_INFO_W]);
    assign rd_next = ram_rdata[2*TW-1 -: TW];
    assign rd_prev = ram_rdata[TW-1:0];
    assign ram_wdata = {w_info, w_next, w_prev};

    assign tid_in_range  = int'(i_req.task_id) < NUM_TASKS;
    assign idle_in_range = int'(r_idle) < NUM_TASKS;
    assign fix_sel       = !r_fix_v[0];

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // The sequencer never issues a read in a cycle that writes the table, and
    // every read follows the last write, so a read always sees fresh data and
    // no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_req       = r_req;
        n_tgt       = r_tgt;
        n_sw        = r_sw;
        n_status    = r_status;
        n_cur       = r_cur;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_fix_v     = r_fix_v;
        n_fix_a     = r_fix_a;
        n_fix_nx    = r_fix_nx;
        n_fix_d     = r_fix_d;
        n_clr       = r_clr;
        n_rsp       = r_rsp;
        n_rsp_valid = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = r_tgt;
        ram_re    = 1'b0;
        ram_raddr = r_tgt;
        w_info    = rd_info;
        w_next    = rd_next;
        w_prev    = rd_prev;

        case (r_state)
            // Write the reset contents of one entry per cycle.
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                w_next    = '0;
                w_prev    = '0;
                if (r_clr == '0) begin
                    w_info = '{state: TS_RUNNING, prio: TASK0_SLICE,
                               ticks: TASK0_SLICE, in_queue: 1'b0};
                end else if (r_clr == TW'(1)) begin
                    w_info = '{state: TS_BLOCKED, prio: TASK1_SLICE,
                               ticks: TASK1_SLICE, in_queue: 1'b0};
                end else begin
                    w_info = '{state: TS_DIED, prio: '0, ticks: '0, in_queue: 1'b0};
                end
                n_clr = r_clr + TW'(1);
                if (r_clr == TW'(NUM_TASKS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request and pick the entry its checks depend on.
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_sw     = 1'b0;
                    n_status = STATUS_OK;
                    n_fix_v  = '0;
                    case (t_op'(i_req.operation))
                        OP_CREATE, OP_UNBLOCK, OP_EXIT: begin
                            if (tid_in_range) begin
                                n_tgt   = TW'(i_req.task_id);
                                n_state = S_OP_RD;
                            end else begin
                                n_status = STATUS_ILLEGAL;
                                n_state  = S_OUT_RD;
                            end
                        end
                        OP_BLOCK, OP_YIELD: begin
                            n_tgt   = r_cur;
                            n_state = S_OP_RD;
                        end
                        OP_PREEMPT: begin
                            n_state = S_SCH_RD;
                        end
                        default: begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end
                    endcase
                end
            end

            S_OP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_tgt;
                n_state   = S_OP_WR;
            end

            // Check the addressed task and apply the operation to its entry.
            S_OP_WR: begin
                ram_waddr = r_tgt;
                n_ret     = S_OUT_RD;
                n_state   = S_FIX_RD;
                case (t_op'(r_req.operation))
                    OP_CREATE: begin
                        if (rd_info.state != TS_DIED) begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end else begin
                            ram_we         = 1'b1;
                            w_info.state   = TS_READY;
                            w_info.prio    = r_req.priority_req;
                            w_info.ticks   = r_req.priority_req;
                            w_info.in_queue = 1'b1;
                            w_prev         = r_tail;
                            if (r_count == '0) begin
                                n_head = r_tgt;
                            end else begin
                                n_fix_v[0]  = 1'b1;
                                n_fix_a[0]  = r_tail;
                                n_fix_nx[0] = 1'b1;
                                n_fix_d[0]  = r_tgt;
                            end
                            n_tail  = r_tgt;
                            n_count = r_count + CNTW'(1);
                        end
                    end
                    OP_BLOCK: begin
                        if (rd_info.state != TS_RUNNING ||
                            r_req.block_kind > BLOCK_KIND_MAX) begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end else begin
                            ram_we       = 1'b1;
                            w_info.state = t_task_state'(3'(TS_BLOCKED) +
                                                         {1'b0, r_req.block_kind});
                            n_state      = S_SCH_RD;
                        end
                    end
                    OP_UNBLOCK: begin
                        if (!is_sleeping(rd_info.state)) begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end else begin
                            ram_we          = 1'b1;
                            w_info.state    = TS_READY;
                            w_info.in_queue = 1'b1;
                            w_next          = r_head;
                            if (r_count == '0) begin
                                n_tail = r_tgt;
                            end else begin
                                n_fix_v[0]  = 1'b1;
                                n_fix_a[0]  = r_head;
                                n_fix_nx[0] = 1'b0;
                                n_fix_d[0]  = r_tgt;
                            end
                            n_head  = r_tgt;
                            n_count = r_count + CNTW'(1);
                        end
                    end
                    OP_YIELD: begin
                        if (rd_info.state != TS_RUNNING) begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end else begin
                            ram_we          = 1'b1;
                            w_info.state    = TS_READY;
                            w_info.in_queue = 1'b1;
                            w_prev          = r_tail;
                            if (r_count == '0) begin
                                n_head = r_tgt;
                            end else begin
                                n_fix_v[0]  = 1'b1;
                                n_fix_a[0]  = r_tail;
                                n_fix_nx[0] = 1'b1;
                                n_fix_d[0]  = r_tgt;
                            end
                            n_tail  = r_tgt;
                            n_count = r_count + CNTW'(1);
                            n_ret   = S_SCH_RD;
                        end
                    end
                    OP_EXIT: begin
                        if (rd_info.state == TS_DIED) begin
                            n_status = STATUS_ILLEGAL;
                            n_state  = S_OUT_RD;
                        end else begin
                            ram_we          = 1'b1;
                            w_info.state    = TS_DIED;
                            w_info.in_queue = 1'b0;
                            // Unlink a queued task from both neighbors.
                            if (rd_info.in_queue) begin
                                if (r_head == r_tgt) begin
                                    n_head = rd_next;
                                end else begin
                                    n_fix_v[0]  = 1'b1;
                                    n_fix_a[0]  = rd_prev;
                                    n_fix_nx[0] = 1'b1;
                                    n_fix_d[0]  = rd_next;
                                end
                                if (r_tail == r_tgt) begin
                                    n_tail = rd_prev;
                                end else begin
                                    n_fix_v[1]  = 1'b1;
                                    n_fix_a[1]  = rd_next;
                                    n_fix_nx[1] = 1'b0;
                                    n_fix_d[1]  = rd_prev;
                                end
                                n_count = r_count - CNTW'(1);
                            end
                            if (r_req.need_schedule) begin
                                n_ret = S_SCH_RD;
                            end
                        end
                    end
                    default: begin
                        n_status = STATUS_ILLEGAL;
                        n_state  = S_OUT_RD;
                    end
                endcase
            end

            S_SCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur;
                n_state   = S_SCH_WR;
            end

            // A still running current task goes to the tail with a fresh slice.
            S_SCH_WR: begin
                ram_waddr = r_cur;
                if (rd_info.state == TS_RUNNING) begin
                    ram_we          = 1'b1;
                    w_info.state    = TS_READY;
                    w_info.ticks    = rd_info.prio;
                    w_info.in_queue = 1'b1;
                    w_prev          = r_tail;
                    if (r_count == '0) begin
                        n_head = r_cur;
                    end else begin
                        n_fix_v[0]  = 1'b1;
                        n_fix_a[0]  = r_tail;
                        n_fix_nx[0] = 1'b1;
                        n_fix_d[0]  = r_cur;
                    end
                    n_tail  = r_cur;
                    n_count = r_count + CNTW'(1);
                    n_ret   = S_IDL_CHK;
                    n_state = S_FIX_RD;
                end else begin
                    n_state = S_IDL_CHK;
                end
            end

            S_IDL_CHK: begin
                if (r_count != '0) begin
                    n_state = S_POP_RD;
                end else if (idle_in_range) begin
                    n_state = S_IDL_RD;
                end else begin
                    n_status = STATUS_NO_RUNNABLE;
                    n_state  = S_OUT_RD;
                end
            end

            S_IDL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = TW'(r_idle);
                n_state   = S_IDL_WR;
            end

            // The queue is empty here, so a sleeping idle task becomes the only entry.
            S_IDL_WR: begin
                ram_waddr = TW'(r_idle);
                if (is_sleeping(rd_info.state)) begin
                    ram_we          = 1'b1;
                    w_info.state    = TS_READY;
                    w_info.in_queue = 1'b1;
                    w_next          = r_head;
                    n_head          = TW'(r_idle);
                    n_tail          = TW'(r_idle);
                    n_count         = r_count + CNTW'(1);
                    n_state         = S_POP_RD;
                end else begin
                    n_status = STATUS_NO_RUNNABLE;
                    n_state  = S_OUT_RD;
                end
            end

            S_POP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_head;
                n_state   = S_POP_WR;
            end

            // Dispatch the head of the queue.
            S_POP_WR: begin
                ram_we          = 1'b1;
                ram_waddr       = r_head;
                w_info.state    = TS_RUNNING;
                w_info.in_queue = 1'b0;
                n_head          = rd_next;
                if (r_tail == r_head) begin
                    n_tail = rd_prev;
                end else begin
                    n_fix_v[0]  = 1'b1;
                    n_fix_a[0]  = rd_next;
                    n_fix_nx[0] = 1'b0;
                    n_fix_d[0]  = rd_prev;
                end
                n_count = r_count - CNTW'(1);
                n_cur   = r_head;
                n_sw    = 1'b1;
                n_ret   = S_OUT_RD;
                n_state = S_FIX_RD;
            end

            S_FIX_RD: begin
                if (|r_fix_v) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_fix_a[fix_sel];
                    n_state   = S_FIX_WR;
                end else begin
                    n_state = r_ret;
                end
            end

            S_FIX_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_fix_a[fix_sel];
                if (r_fix_nx[fix_sel]) begin
                    w_next = r_fix_d[fix_sel];
                end else begin
                    w_prev = r_fix_d[fix_sel];
                end
                n_fix_v[fix_sel] = 1'b0;
                n_state          = S_FIX_RD;
            end

            S_OUT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur;
                n_state   = S_OUT;
            end

            S_OUT: begin
                n_rsp.running_task = TASK_ID_W'(r_cur);
                n_rsp.switched     = r_sw;
                n_rsp.slice_ticks  = rd_info.ticks;
                n_rsp.status_code  = r_status;
                n_rsp_valid        = 1'b1;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_OUT_RD;
            r_sw        <= 1'b0;
            r_status    <= STATUS_OK;
            r_cur       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_idle      <= TASK_ID_W'(1);
            r_fix_v     <= '0;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_sw        <= n_sw;
            r_status    <= n_status;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fix_v     <= n_fix_v;
            r_clr       <= n_clr;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                r_idle <= i_idle_task;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_tgt    <= n_tgt;
        r_fix_a  <= n_fix_a;
        r_fix_nx <= n_fix_nx;
        r_fix_d  <= n_fix_d;
        r_rsp    <= n_rsp;
    end

    // A read and a write of the task table never share a cycle.
    `ASSERT_NEVER(a_no_table_rw_overlap, i_clk, i_rst_n, ram_we && ram_re)
    // An accepted request keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy)
    // A result strobe only follows the result read of the running task.
    `ASSERT_IMPLIES(a_rsp_after_out, i_clk, i_rst_n, o_rsp_valid, $past(r_state == S_OUT))
    // A dispatch is always reported with an ok status.
    `ASSERT_IMPLIES(a_switch_is_ok, i_clk, i_rst_n, o_rsp_valid && o_rsp.switched,
                    o_rsp.status_code == STATUS_OK)
    // The ready queue never holds more entries than there are tasks.
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, int'(r_count) > NUM_TASKS)

endmodule

`default_nettype wire

>>> tb/round_robin_task_scheduler_unit_tb.sv
// ============================================================================
// Round robin task scheduler testbench
// Drives create, block, unblock, yield, preempt, exit and the reserved
// operation codes into the scheduler. A behavioral copy of the ready queue
// and the task tables predicts every result transaction, and a monitor
// compares each result, field by field, with the oldest prediction. The run
// opens with a directed walk through the special cases and then sends
// several phases of biased random traffic, each under its own idle task.
// ============================================================================
`timescale 1ns / 100ps

module tb;
    import rrts_pkg::*;

    localparam int NUM_TASKS   = 64;
    localparam int PHASE_ITEMS = 225;
    localparam int NUM_PHASES  = 6;
    localparam int MAX_REPORTS = 40;

    // The two operation codes that the package leaves unassigned.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Classes of task that the random traffic aims its requests at.
    typedef enum int {
        PICK_DEAD,
        PICK_DORMANT,
        PICK_LIVE
    } t_pick;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input holds a known value
    // from time zero.
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_sched_req i_req       = '0;
    logic       o_rsp_valid;
    t_sched_rsp o_rsp;
    logic       i_cfg_we    = 1'b0;
    logic [TASK_ID_W-1:0] i_idle_task = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    round_robin_task_scheduler_unit #(
        .NUM_TASKS (NUM_TASKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_idle_task (i_idle_task)
    );

    // ------------------------------------------------------------------------
    // Scheduler shadow. It mirrors the per-task tables and the ready queue
    // and is advanced once per accepted request transaction, in order.
    // ------------------------------------------------------------------------
    t_task_state          shadow_state [NUM_TASKS];
    logic [SLICE_W-1:0]   shadow_prio  [NUM_TASKS];
    logic [SLICE_W-1:0]   shadow_ticks [NUM_TASKS];
    int                   link_next    [NUM_TASKS];
    int                   link_prev    [NUM_TASKS];
    bit                   queued       [NUM_TASKS];
    int                   ready_head;
    int                   ready_tail;
    int                   ready_count;
    int                   running_id;
    logic [TASK_ID_W-1:0] idle_sel;

    // Results that the block still owes, oldest first.
    t_sched_rsp awaited_rsp_q[$];
    int         mismatch_count = 0;

    function automatic void reset_shadow();
        for (int t = 0; t < NUM_TASKS; t++) begin
            shadow_state[t] = TS_DIED;
            shadow_prio[t]  = '0;
            shadow_ticks[t] = '0;
            link_next[t]    = 0;
            link_prev[t]    = 0;
            queued[t]       = 1'b0;
        end
        shadow_state[0] = TS_RUNNING;
        shadow_prio[0]  = TASK0_SLICE;
        shadow_ticks[0] = TASK0_SLICE;
        shadow_state[1] = TS_BLOCKED;
        shadow_prio[1]  = TASK1_SLICE;
        shadow_ticks[1] = TASK1_SLICE;
        ready_head  = 0;
        ready_tail  = 0;
        ready_count = 0;
        running_id  = 0;
        idle_sel    = 6'd1;
    endfunction

    function automatic bit dormant(input int t);
        return shadow_state[t] inside {TS_BLOCKED, TS_WAITING, TS_HANGING};
    endfunction

    function automatic void link_at_tail(input int t);
        if (ready_count == 0) begin
            ready_head = t;
        end else begin
            link_next[ready_tail] = t;
            link_prev[t] = ready_tail;
        end
        ready_tail = t;
        queued[t] = 1'b1;
        ready_count++;
    endfunction

    function automatic void link_at_head(input int t);
        if (ready_count == 0) begin
            ready_tail = t;
        end else begin
            link_prev[ready_head] = t;
            link_next[t] = ready_head;
        end
        ready_head = t;
        queued[t] = 1'b1;
        ready_count++;
    endfunction

    function automatic void unlink(input int t);
        if (ready_head == t) begin
            ready_head = link_next[t];
        end else begin
            link_next[link_prev[t]] = link_next[t];
        end
        if (ready_tail == t) begin
            ready_tail = link_prev[t];
        end else begin
            link_prev[link_next[t]] = link_prev[t];
        end
        queued[t] = 1'b0;
        ready_count--;
    endfunction

    function automatic void wake(input int t);
        link_at_head(t);
        shadow_state[t] = TS_READY;
    endfunction

    // Picks the next running task. A task that is still running goes to the
    // back of the queue with a fresh slice; an empty queue falls back on the
    // idle task when that task is asleep.
    function automatic logic [1:0] dispatch_next(output bit dispatched);
        int cur;
        int nxt;
        cur = running_id;
        dispatched = 1'b0;
        if (shadow_state[cur] == TS_RUNNING) begin
            link_at_tail(cur);
            shadow_ticks[cur] = shadow_prio[cur];
            shadow_state[cur] = TS_READY;
        end
        if (ready_count == 0 && int'(idle_sel) < NUM_TASKS && dormant(idle_sel)) begin
            wake(idle_sel);
        end
        if (ready_count == 0) begin
            return STATUS_NO_RUNNABLE;
        end
        nxt = ready_head;
        unlink(nxt);
        shadow_state[nxt] = TS_RUNNING;
        running_id = nxt;
        dispatched = 1'b1;
        return STATUS_OK;
    endfunction

    // Applies one request to the shadow and returns the result it must give.
    function automatic t_sched_rsp sched_outcome(input t_sched_req r);
        t_sched_rsp rsp;
        bit         dispatched;
        logic [1:0] status;
        int         tid;
        int         cur;
        tid = r.task_id;
        cur = running_id;
        dispatched = 1'b0;
        status = STATUS_OK;
        case (r.operation)
            OP_CREATE: begin
                if (tid >= NUM_TASKS || shadow_state[tid] != TS_DIED) begin
                    status = STATUS_ILLEGAL;
                end else begin
                    shadow_state[tid] = TS_READY;
                    shadow_prio[tid]  = r.priority_req;
                    shadow_ticks[tid] = r.priority_req;
                    link_at_tail(tid);
                end
            end
            OP_BLOCK: begin
                if (shadow_state[cur] != TS_RUNNING || r.block_kind > BLOCK_KIND_MAX) begin
                    status = STATUS_ILLEGAL;
                end else begin
                    shadow_state[cur] = t_task_state'(TS_BLOCKED + r.block_kind);
                    status = dispatch_next(dispatched);
                end
            end
            OP_UNBLOCK: begin
                if (tid >= NUM_TASKS || !dormant(tid)) begin
                    status = STATUS_ILLEGAL;
                end else begin
                    wake(tid);
                end
            end
            OP_YIELD: begin
                if (shadow_state[cur] != TS_RUNNING) begin
                    status = STATUS_ILLEGAL;
                end else begin
                    // Yield keeps the remaining slice: no reload here.
                    link_at_tail(cur);
                    shadow_state[cur] = TS_READY;
                    status = dispatch_next(dispatched);
                end
            end
            OP_PREEMPT: begin
                status = dispatch_next(dispatched);
            end
            OP_EXIT: begin
                if (tid >= NUM_TASKS || shadow_state[tid] == TS_DIED) begin
                    status = STATUS_ILLEGAL;
                end else begin
                    shadow_state[tid] = TS_DIED;
                    if (queued[tid]) begin
                        unlink(tid);
                    end
                    if (r.need_schedule) begin
                        status = dispatch_next(dispatched);
                    end
                end
            end
            default: begin
                status = STATUS_ILLEGAL;
            end
        endcase
        rsp.running_task = running_id;
        rsp.switched     = dispatched;
        rsp.slice_ticks  = shadow_ticks[running_id];
        rsp.status_code  = status;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor. A result is shown for exactly one cycle between rising
    // edges, so sampling it at the falling edge sees it once and stays clear
    // of the block's own updates at the rising edge.
    // ------------------------------------------------------------------------
    task automatic report_field(input string field, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(negedge i_clk) begin
        t_sched_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid === 1'b1) begin
            if (awaited_rsp_q.size() == 0) begin
                report_field("unexpected result, running_task", -1, o_rsp.running_task);
            end else begin
                exp_rsp = awaited_rsp_q.pop_front();
                if (o_rsp.running_task !== exp_rsp.running_task) begin
                    report_field("running_task", exp_rsp.running_task, o_rsp.running_task);
                end
                if (o_rsp.switched !== exp_rsp.switched) begin
                    report_field("switched", exp_rsp.switched, o_rsp.switched);
                end
                if (o_rsp.slice_ticks !== exp_rsp.slice_ticks) begin
                    report_field("slice_ticks", exp_rsp.slice_ticks, o_rsp.slice_ticks);
                end
                if (o_rsp.status_code !== exp_rsp.status_code) begin
                    report_field("status_code", exp_rsp.status_code, o_rsp.status_code);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All of them are entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int next_gap(input bit allow_gaps);
        int roll;
        roll = $urandom_range(0, 99);
        if (!allow_gaps || roll < 55) begin
            return 0;
        end else if (roll < 87) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Presents one request transaction and holds it until the block takes
    // it. Busy is sampled at the falling edge, so a low sample means the
    // next rising edge accepts the request. With no gap, start stays high
    // for the following request.
    task automatic send_item(input t_sched_req r, input int gap);
        logic was_busy;
        start <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy !== 1'b0);
        awaited_rsp_q.push_back(sched_outcome(r));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every request gives exactly one result, so the block is idle once the
    // last awaited result has been seen.
    task automatic wait_for_results();
        start <= 1'b0;
        while (awaited_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idle_task(input logic [TASK_ID_W-1:0] id);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_idle_task <= id;
        idle_sel = id;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_sched_req make_req(input logic [2:0] op, input int tid,
                                            input int prio, input int kind,
                                            input bit need);
        t_sched_req r;
        r.operation     = op;
        r.task_id       = tid;
        r.priority_req  = prio;
        r.block_kind    = kind;
        r.need_schedule = need;
        return r;
    endfunction

    // Aims most requests at a task for which they are legal, using the shadow
    // to find one; the rest keep the random task number.
    function automatic int pick_task(input t_pick cls, input int fallback);
        int cands[$];
        bit hit;
        if ($urandom_range(0, 99) >= 85) begin
            return fallback;
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
            case (cls)
                PICK_DEAD:    hit = shadow_state[t] == TS_DIED;
                PICK_DORMANT: hit = dormant(t);
                default:      hit = shadow_state[t] != TS_DIED;
            endcase
            if (hit) begin
                cands.push_back(t);
            end
        end
        if (cands.size() == 0) begin
            return fallback;
        end
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function automatic t_sched_req random_req();
        t_sched_req r;
        int         roll;
        r.task_id       = $urandom;
        r.priority_req  = $urandom;
        r.need_schedule = $urandom;
        r.block_kind    = ($urandom_range(0, 9) == 0) ? 2'd3 : $urandom_range(0, 2);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            r.operation = roll[0] ? OP_RSVD7 : OP_RSVD6;
        end else if (roll < 23) begin
            r.operation = OP_CREATE;
            r.task_id = pick_task(PICK_DEAD, r.task_id);
        end else if (roll < 37) begin
            r.operation = OP_BLOCK;
        end else if (roll < 53) begin
            r.operation = OP_UNBLOCK;
            r.task_id = pick_task(PICK_DORMANT, r.task_id);
        end else if (roll < 67) begin
            r.operation = OP_YIELD;
        end else if (roll < 82) begin
            r.operation = OP_PREEMPT;
        end else begin
            r.operation = OP_EXIT;
            r.task_id = pick_task(PICK_LIVE, r.task_id);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walks from the reset state through every operation and every special
    // case: illegal block kinds, double create, unblocking a ready task, a
    // reschedule that re-dispatches the same task, exit with and without a
    // reschedule, the idle task fallback, the no runnable task case and the
    // reserved operation codes. Task numbers and slices hit their extremes.
    task automatic test_directed_ops();
        send_item(make_req(OP_BLOCK,   0,  0,   3, 0), next_gap(1)); // kind 3 is illegal
        send_item(make_req(OP_CREATE,  63, 255, 0, 0), next_gap(1));
        send_item(make_req(OP_CREATE,  63, 7,   0, 1), next_gap(1)); // not dead: illegal
        send_item(make_req(OP_YIELD,   5,  0,   0, 0), next_gap(1)); // task 63 takes over
        send_item(make_req(OP_UNBLOCK, 1,  0,   0, 0), next_gap(1));
        send_item(make_req(OP_UNBLOCK, 1,  0,   0, 0), next_gap(1)); // already ready
        send_item(make_req(OP_PREEMPT, 0,  0,   0, 0), next_gap(1)); // task 1 from the front
        send_item(make_req(OP_BLOCK,   0,  0,   1, 0), next_gap(1)); // waiting
        send_item(make_req(OP_BLOCK,   0,  0,   2, 0), next_gap(1)); // hanging
        send_item(make_req(OP_EXIT,    0,  0,   0, 0), next_gap(1)); // sleeping task dies
        send_item(make_req(OP_EXIT,    0,  0,   0, 1), next_gap(1)); // already dead
        send_item(make_req(OP_CREATE,  0,  0,   0, 0), next_gap(1));
        // Another task exits with a reschedule: the running task goes round
        // the queue and is dispatched again.
        send_item(make_req(OP_EXIT,    0,  0,   0, 1), next_gap(1));
        // Empty queue: the waiting idle task is woken and dispatched.
        send_item(make_req(OP_BLOCK,   0,  0,   0, 0), next_gap(1));
        send_item(make_req(OP_EXIT,    1,  0,   0, 0), next_gap(1)); // running task dies
        send_item(make_req(OP_YIELD,   0,  0,   0, 0), next_gap(1)); // nothing running
        send_item(make_req(OP_PREEMPT, 0,  0,   0, 0), next_gap(1)); // nothing runnable
        send_item(make_req(OP_RSVD6,   63, 255, 3, 1), next_gap(1));
        send_item(make_req(OP_RSVD7,   0,  0,   0, 0), next_gap(1));
        send_item(make_req(OP_UNBLOCK, 63, 0,   0, 0), next_gap(1));
        send_item(make_req(OP_PREEMPT, 0,  0,   0, 0), next_gap(1));
        send_item(make_req(OP_BLOCK,   0,  128, 0, 0), next_gap(1)); // idle task is dead
        send_item(make_req(OP_CREATE,  1,  1,   0, 0), next_gap(1));
        send_item(make_req(OP_PREEMPT, 0,  0,   0, 0), next_gap(1));
    endtask

    // One phase of random traffic under a given idle task.
    task automatic test_random_mix(input logic [TASK_ID_W-1:0] idle_id, input int n_items,
                                   input bit allow_gaps);
        set_idle_task(idle_id);
        for (int i = 0; i < n_items; i++) begin
            send_item(random_req(), next_gap(allow_gaps));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its task table after reset with busy high; the
        // first request simply waits for busy to drop.
        test_directed_ops();
        // The extremes of the idle task come first; phase 2 runs with no
        // idle cycles between requests.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       test_random_mix(6'd0,  PHASE_ITEMS, 1'b1);
                1:       test_random_mix(6'd63, PHASE_ITEMS, 1'b1);
                2:       test_random_mix(6'd1,  PHASE_ITEMS, 1'b0);
                default: test_random_mix($urandom_range(0, NUM_TASKS - 1), PHASE_ITEMS, 1'b1);
            endcase
        end
        wait_for_results();
        // Any stray result would show up within the longest operation.
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_ram.sv
rtl/core/round_robin_task_scheduler_unit.sv
tb/round_robin_task_scheduler_unit_tb.sv
